// File: hw/rtl/line_ending_converter_assert.svh
// ----------------------------------------------------------------------------
// line ending converter assertion macros
// clocked assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef LINE_ENDING_CONVERTER_ASSERT_SVH
`define LINE_ENDING_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset
`define LEC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked on every edge, reset included
`define LEC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define LEC_ASSERT(label, prop, msg)
`define LEC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: hw/rtl/lec_pkg.sv
// ----------------------------------------------------------------------------
// lec_pkg
// types and constants shared by the line ending converter
// ----------------------------------------------------------------------------
package lec_pkg;

   localparam logic [1:0] MODE_ADD     = 2'd0;
   localparam logic [1:0] MODE_REMOVE  = 2'd1;
   localparam logic [1:0] MODE_INSPECT = 2'd2;

   localparam logic [1:0] VERDICT_UNIX   = 2'd0;
   localparam logic [1:0] VERDICT_MSDOS  = 2'd1;
   localparam logic [1:0] VERDICT_BINARY = 2'd2;

   localparam logic CSR_MODE  = 1'b0;
   localparam logic CSR_FORCE = 1'b1;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_CTRLZ   = 8'h1A;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;
   localparam logic [7:0] HIGH_START = 8'h80;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       kind;
      logic [1:0] verdict;
      logic       keep_output;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic pending_cr;
      logic pending_ctrl_z;
      logic prev_was_cr;
      logic seen_bare_lf;
      logic seen_crlf;
      logic binary_abort;
   } file_state_type;

   // results of one item handed to the result queue
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

   function automatic logic is_binary(input logic [7:0] b);
      return (b != CH_TAB) && ((b < CTRL_LIMIT) || (b >= HIGH_START));
   endfunction

endpackage

// File: hw/rtl/lec_core.sv
// ----------------------------------------------------------------------------
// lec_core
// input register, per-file state and the conversion logic for one item
// ----------------------------------------------------------------------------
`include "line_ending_converter_assert.svh"

module lec_core
   import lec_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   input  logic [1:0]   mode,
   input  logic         force_cfg,
   input  logic [1:0]   room,
   output push_type     push
);

   logic           a_valid_ff, a_valid_in;
   req_item_type   a_item_ff, a_item_in;
   file_state_type state_ff, state_in;

   file_state_type   st;
   logic [1:0]       ecnt;
   logic [1:0][7:0]  ebytes;
   logic             is_eof;
   logic [1:0]       verdict;
   logic             keep;
   logic             outp;
   logic             frc_eff;
   logic             done;
   logic [7:0]       b;
   logic [1:0]       n_res;
   logic             a_fire;
   rsp_item_type     data0, data1, vitem;

   always_comb begin
      st      = state_ff;
      ecnt    = 2'd0;
      ebytes  = '0;
      verdict = VERDICT_UNIX;
      keep    = 1'b0;
      done    = 1'b0;
      b       = a_item_ff.data_byte;
      is_eof  = a_item_ff.end_of_file;
      outp    = (mode == MODE_REMOVE);
      frc_eff = outp && force_cfg;
      if (is_eof) begin
         if (outp && !state_ff.binary_abort && state_ff.pending_cr) begin
            ebytes[0] = CH_CR;
            ecnt      = 2'd1;
         end
         if (state_ff.binary_abort) begin
            verdict = VERDICT_BINARY;
         end else if (mode == MODE_ADD) begin
            if (force_cfg) begin
               verdict = VERDICT_UNIX;
               keep    = 1'b1;
            end else if (state_ff.seen_crlf) begin
               verdict = VERDICT_MSDOS;
            end else if (state_ff.seen_bare_lf) begin
               verdict = VERDICT_UNIX;
               keep    = 1'b1;
            end else begin
               verdict = VERDICT_BINARY;
            end
         end else begin
            if (frc_eff) begin
               verdict = VERDICT_MSDOS;
               keep    = 1'b1;
            end else if (state_ff.seen_bare_lf) begin
               verdict = VERDICT_UNIX;
            end else if (state_ff.seen_crlf) begin
               verdict = VERDICT_MSDOS;
               keep    = outp;
            end else begin
               verdict = VERDICT_BINARY;
            end
         end
         st = '0;
      end else if (state_ff.binary_abort) begin
         // aborted file: bytes are dropped until the end item
      end else if (mode == MODE_ADD) begin
         st.pending_cr     = 1'b0;
         st.pending_ctrl_z = 1'b0;
         if (b == CH_CR) begin
            st.prev_was_cr = 1'b1;
            ebytes[0]      = CH_CR;
            ecnt           = 2'd1;
         end else begin
            if (b == CH_LF) begin
               st.seen_crlf    = state_ff.seen_crlf | state_ff.prev_was_cr;
               st.seen_bare_lf = 1'b1;
               ebytes[0]       = CH_CR;
               ebytes[1]       = CH_LF;
               ecnt            = 2'd2;
            end else if (is_binary(b) && !force_cfg) begin
               st.binary_abort = 1'b1;
            end else begin
               ebytes[0] = b;
               ecnt      = 2'd1;
            end
            st.prev_was_cr = 1'b0;
         end
      end else begin
         if (state_ff.pending_ctrl_z) begin
            st.pending_ctrl_z = 1'b0;
            if (!frc_eff) begin
               // a ctrl-z that is not the last byte makes the file binary
               st.binary_abort = 1'b1;
               st.pending_cr   = 1'b0;
               done            = 1'b1;
            end else begin
               ebytes[ecnt[0]] = CH_CTRLZ;
               ecnt            = ecnt + 2'd1;
            end
         end
         if (!done && state_ff.pending_cr) begin
            st.pending_cr = 1'b0;
            if (b == CH_LF) begin
               st.seen_crlf = 1'b1;
               if (outp) begin
                  ebytes[ecnt[0]] = CH_LF;
                  ecnt            = ecnt + 2'd1;
               end
               done = 1'b1;
            end else if (outp) begin
               ebytes[ecnt[0]] = CH_CR;
               ecnt            = ecnt + 2'd1;
            end
         end
         if (!done) begin
            if (b == CH_CR) begin
               st.pending_cr = 1'b1;
            end else if (b == CH_LF) begin
               st.seen_bare_lf = 1'b1;
               if (outp) begin
                  ebytes[ecnt[0]] = CH_LF;
                  ecnt            = ecnt + 2'd1;
               end
            end else if (is_binary(b)) begin
               if (b == CH_CTRLZ) begin
                  st.pending_ctrl_z = 1'b1;
               end else if (!frc_eff) begin
                  st.binary_abort   = 1'b1;
                  st.pending_cr     = 1'b0;
                  st.pending_ctrl_z = 1'b0;
               end else begin
                  ebytes[ecnt[0]] = b;
                  ecnt            = ecnt + 2'd1;
               end
            end else if (outp) begin
               ebytes[ecnt[0]] = b;
               ecnt            = ecnt + 2'd1;
            end
         end
      end
   end

   always_comb begin
      data0 = '{out_byte: ebytes[0], kind: KIND_DATA, verdict: VERDICT_UNIX,
                keep_output: 1'b0, last: 1'b0};
      data1 = '{out_byte: ebytes[1], kind: KIND_DATA, verdict: VERDICT_UNIX,
                keep_output: 1'b0, last: 1'b0};
      vitem = '{out_byte: 8'h00, kind: KIND_VERDICT, verdict: verdict,
                keep_output: keep, last: 1'b1};
      n_res = is_eof ? (ecnt + 2'd1) : ecnt;
      a_fire = a_valid_ff && (n_res <= room);
      req_stall = a_valid_ff && !a_fire;
      push.count  = a_fire ? n_res : 2'd0;
      push.first  = (is_eof && (ecnt == 2'd0)) ? vitem : data0;
      push.second = is_eof ? vitem : data1;
   end

   always_comb begin
      a_valid_in = a_valid_ff && !a_fire;
      a_item_in  = a_item_ff;
      if (!req_stall) begin
         a_valid_in = req_valid;
         a_item_in  = req_item;
      end
      state_in = a_fire ? st : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         state_ff   <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         state_ff   <= state_in;
      end
      a_item_ff <= a_item_in;
   end

   `LEC_ASSERT(a_eof_clears_state, a_fire && a_item_ff.end_of_file |=> state_ff == '0,
               "per-file state not cleared after end item")
   `LEC_ASSERT(a_abort_silent,
               a_fire && state_ff.binary_abort && !a_item_ff.end_of_file |-> push.count == 2'd0,
               "aborted file produced data")
   `LEC_ASSERT(a_no_overflow, push.count <= room,
               "more results pushed than queue room")

endmodule

// File: hw/rtl/lec_out_queue.sv
// ----------------------------------------------------------------------------
// lec_out_queue
// two-entry result buffer that drives the result channel
// ----------------------------------------------------------------------------
`include "line_ending_converter_assert.svh"

module lec_out_queue
   import lec_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   output logic [1:0]   room,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic [1:0]   cnt_ff, cnt_in;
   rsp_item_type q0_ff, q0_in, q1_ff, q1_in;
   logic         pop;
   logic [1:0]   kept;

   always_comb begin
      pop       = (cnt_ff != 2'd0) && !rsp_stall;
      rsp_valid = (cnt_ff != 2'd0);
      rsp_item  = q0_ff;
      unique case (cnt_ff)
         2'd0:    room = 2'd2;
         2'd1:    room = pop ? 2'd2 : 2'd1;
         2'd2:    room = pop ? 2'd1 : 2'd0;
         default: room = 2'd0;
      endcase
      kept  = pop ? (cnt_ff - 2'd1) : cnt_ff;
      q0_in = pop ? q1_ff : q0_ff;
      q1_in = q1_ff;
      if (push.count != 2'd0) begin
         if (kept == 2'd0) begin
            q0_in = push.first;
         end else begin
            q1_in = push.first;
         end
      end
      if (push.count == 2'd2) begin
         q1_in = push.second;
      end
      cnt_in = kept + push.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   `LEC_ASSERT(a_cnt_range, cnt_ff != 2'd3, "result queue count out of range")
   `LEC_ASSERT(a_cnt_track, push.count == 2'd0 && pop |=> cnt_ff == $past(cnt_ff) - 2'd1,
               "result queue count lost an entry")

endmodule

// File: hw/rtl/line_ending_converter.sv
// ----------------------------------------------------------------------------
// line_ending_converter
// CR/LF line ending converter: add, remove or inspect, with binary detection
// ----------------------------------------------------------------------------
// path: an accepted item passes the input register, then the result queue, before
//    its first result; a second result of the same item follows it from the queue
// throughput: one item per cycle while the result queue has room; an item with two
//    results holds the input until the two-entry result queue has room for both
// reset: synchronous, clears mode, force, per-file state, the input register
//    and the result queue
`include "line_ending_converter_assert.svh"

module line_ending_converter
   import lec_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [1:0]   csr_wdata
);

   logic [1:0] mode_ff, mode_in;
   logic       force_ff, force_in;
   logic [1:0] room;
   push_type   push;

   always_comb begin
      csr_ready = 1'b1;
      mode_in   = mode_ff;
      force_in  = force_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:  mode_in  = csr_wdata;
            CSR_FORCE: force_in = csr_wdata[0];
            default:   mode_in  = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ADD;
         force_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         force_ff <= force_in;
      end
   end

   lec_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .mode      (mode_ff),
      .force_cfg (force_ff),
      .room      (room),
      .push      (push)
   );

   lec_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   `LEC_ASSERT(a_verdict_last, rsp_valid && rsp_item.kind == KIND_VERDICT |-> rsp_item.last,
               "verdict word without last")

endmodule
